### hdl/sbh_pkg.sv
package sbh_pkg;

  localparam int ANGLE_W = 12;
  localparam int OP_W    = 3;
  localparam int LIMB_W  = 2;
  localparam int JOINT_W = 3;
  localparam int CHAN_W  = 4;
  localparam int CFG_IDX_W = 2;

  localparam int NUM_LIMBS_DEFAULT       = 4;
  localparam int JOINTS_PER_LIMB_DEFAULT = 5;

  // one degree in fixed point
  localparam logic [ANGLE_W-1:0] STEP_ANGLE = ANGLE_W'(16);
  localparam logic [ANGLE_W-1:0] MIN_RESET  = '0;
  localparam logic [ANGLE_W-1:0] MAX_RESET  = ANGLE_W'(2880);

  typedef enum logic [OP_W-1:0] {
    OP_SET      = 3'd0,
    OP_TICK     = 3'd1,
    OP_CAPTURE  = 3'd2,
    OP_LOAD     = 3'd3,
    OP_SET_FLAG = 3'd4
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_ANGLE = 2'd0,
    REG_MAX_ANGLE = 2'd1,
    REG_MOVE_EN   = 2'd2
  } cfg_reg_t;

  localparam logic [ANGLE_W-1:0] START_TAB [4] = '{
    12'd960, 12'd640, 12'd2560, 12'd160
  };

  localparam logic [ANGLE_W-1:0] HOME_TAB [4][5] = '{
    '{12'd1440, 12'd2464, 12'd1600, 12'd1504, 12'd1376},
    '{12'd1504, 12'd48,   12'd1392, 12'd1504, 12'd1376},
    '{12'd1344, 12'd1328, 12'd272,  12'd1456, 12'd1328},
    '{12'd1288, 12'd1552, 12'd2496, 12'd1504, 12'd1496}
  };

  // write request into the angle file
  typedef struct packed {
    logic               cur_we;
    logic               home_we;
    logic [ANGLE_W-1:0] cur_wdata;
    logic [ANGLE_W-1:0] home_wdata;
  } wr_req_t;

  // result of the shared slew and clamp unit
  typedef struct packed {
    logic               step;
    logic               limited;
    logic [ANGLE_W-1:0] value;
  } slew_res_t;

  function automatic logic [ANGLE_W-1:0] start_angle(input logic [LIMB_W-1:0] limb);
    return START_TAB[limb];
  endfunction

  function automatic logic [ANGLE_W-1:0] home_reset(input logic [LIMB_W-1:0] limb,
                                                    input int joint);
    logic [ANGLE_W-1:0] res;
    if (joint < 5) begin
      res = HOME_TAB[limb][JOINT_W'(joint)];
    end else begin
      res = START_TAB[limb];
    end
    return res;
  endfunction

endpackage

### hdl/sbh_angle_file.sv
module sbh_angle_file
  import sbh_pkg::*;
#(
  parameter int NUM_LIMBS       = NUM_LIMBS_DEFAULT,
  parameter int JOINTS_PER_LIMB = JOINTS_PER_LIMB_DEFAULT,
  parameter int NSERVO          = NUM_LIMBS * JOINTS_PER_LIMB,
  parameter int IDX_W           = (NSERVO > 1) ? $clog2(NSERVO) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [IDX_W-1:0]   idx,
  input  wr_req_t            wr,
  output logic [ANGLE_W-1:0] cur_rd,
  output logic [ANGLE_W-1:0] home_rd
);

  logic [ANGLE_W-1:0] cur  [NSERVO];
  logic [ANGLE_W-1:0] home [NSERVO];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < NUM_LIMBS; l++) begin
        for (int j = 0; j < JOINTS_PER_LIMB; j++) begin
          cur[l*JOINTS_PER_LIMB + j]  <= start_angle(LIMB_W'(l));
          home[l*JOINTS_PER_LIMB + j] <= home_reset(LIMB_W'(l), j);
        end
      end
    end else begin
      if (wr.cur_we) begin
        cur[idx] <= wr.cur_wdata;
      end
      if (wr.home_we) begin
        home[idx] <= wr.home_wdata;
      end
    end
  end

  // addresses past the bank are never written, keep the read clean anyway
  always_comb begin
    if (int'(idx) < NSERVO) begin
      cur_rd  = cur[idx];
      home_rd = home[idx];
    end else begin
      cur_rd  = '0;
      home_rd = '0;
    end
  end

endmodule

### hdl/sbh_slew_unit.sv
module sbh_slew_unit
  import sbh_pkg::*;
(
  input  logic               set_mode,
  input  logic [ANGLE_W-1:0] cur,
  input  logic [ANGLE_W-1:0] home,
  input  logic [ANGLE_W-1:0] angle,
  input  logic [ANGLE_W-1:0] min_angle,
  input  logic [ANGLE_W-1:0] max_angle,
  output slew_res_t          res
);

  logic signed [ANGLE_W:0] diff;
  logic                    step_down;
  logic                    step_up;
  logic [ANGLE_W:0]        target;
  logic [ANGLE_W:0]        raised;
  logic                    lim_lo;
  logic                    lim_hi;

  always_comb begin
    diff      = $signed({1'b0, cur}) - $signed({1'b0, home});
    step_down = diff > $signed({1'b0, STEP_ANGLE});
    step_up   = diff < -$signed({1'b0, STEP_ANGLE});

    if (set_mode) begin
      target = {1'b0, angle};
    end else if (step_down) begin
      target = {1'b0, cur} - {1'b0, STEP_ANGLE};
    end else begin
      target = {1'b0, cur} + {1'b0, STEP_ANGLE};
    end

    // raise to min first, then lower to max
    lim_lo = target < {1'b0, min_angle};
    raised = lim_lo ? {1'b0, min_angle} : target;
    lim_hi = raised > {1'b0, max_angle};

    res.step    = step_down | step_up;
    res.limited = lim_lo | lim_hi;
    res.value   = lim_hi ? max_angle : raised[ANGLE_W-1:0];
  end

endmodule

### hdl/servo_bank_homing_stepper.sv
// channel   dir  handshake          payload
// s_axis    in   s_tvalid/s_tready  s_tuser operation, s_tdata servo request
// m_axis    out  m_tvalid/m_tready  m_tuser command_valid, m_tdata, m_tlast
// cfg       in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// a running homing tick scans the bank twice through the one slew unit,
// with a status result added when no servo steps; output stalls hold it.
// one request at a time; s_tready is high only while idle.
// rst is synchronous; angles and home table come back to their start values.
module servo_bank_homing_stepper
  import sbh_pkg::*;
#(
  parameter int NUM_LIMBS       = NUM_LIMBS_DEFAULT,
  parameter int JOINTS_PER_LIMB = JOINTS_PER_LIMB_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [23:0]          s_tdata,   // limb, joint, angle, flag_value
  input  logic [OP_W-1:0]      s_tuser,   // operation
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [23:0]          m_tdata,   // board, channel, servo_angle, limited,
                                          // flag_changed, homing_active
  output logic                 m_tuser,   // command_valid
  output logic                 m_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ANGLE_W-1:0]   cfg_data
);

  localparam int NSERVO = NUM_LIMBS * JOINTS_PER_LIMB;
  localparam int IDX_W  = (NSERVO > 1) ? $clog2(NSERVO) : 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SET, ST_SCAN, ST_WALK, ST_COPY, ST_LOAD, ST_FINISH
  } state_t;

  state_t             state;
  logic [OP_W-1:0]    op;
  logic [ANGLE_W-1:0] angle;
  logic               addr_ok;
  logic [LIMB_W-1:0]  l_cnt;
  logic [JOINT_W-1:0] j_cnt;
  logic [IDX_W-1:0]   i_cnt;
  logic [IDX_W-1:0]   last_i;
  logic               found;
  logic               homing_flag;
  logic               flag_chg;
  logic [ANGLE_W-1:0] min_angle;
  logic [ANGLE_W-1:0] max_angle;
  logic               move_en;

  logic               o_board;
  logic [CHAN_W-1:0]  o_chan;
  logic [ANGLE_W-1:0] o_angle;
  logic               o_cmd;
  logic               o_lim;
  logic               o_chg;
  logic               o_active;

  logic [LIMB_W-1:0]  in_limb;
  logic [JOINT_W-1:0] in_joint;
  logic [ANGLE_W-1:0] in_angle;
  logic               in_flag;
  logic               in_ok;
  logic               slot_free;
  logic               out_load;
  logic               at_end;
  logic [CHAN_W-1:0]  cnt_chan;

  wr_req_t            wr;
  slew_res_t          slew;
  logic [ANGLE_W-1:0] cur_rd;
  logic [ANGLE_W-1:0] home_rd;

  assign in_limb  = s_tdata[1:0];
  assign in_joint = s_tdata[4:2];
  assign in_angle = s_tdata[16:5];
  assign in_flag  = s_tdata[17];
  assign in_ok    = (int'(in_limb) < NUM_LIMBS) && (int'(in_joint) < JOINTS_PER_LIMB);

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign slot_free = !m_tvalid || m_tready;
  assign out_load  = slot_free && ((state == ST_SET) || (state == ST_FINISH) ||
                                   ((state == ST_WALK) && slew.step));
  assign at_end    = (i_cnt == IDX_W'(NSERVO - 1));
  assign cnt_chan  = (l_cnt[0] ? CHAN_W'(JOINTS_PER_LIMB) : '0) + CHAN_W'(j_cnt);

  assign m_tdata = {4'b0, o_active, o_chg, o_lim, o_angle, o_chan, o_board};
  assign m_tuser = o_cmd;

  sbh_angle_file #(
    .NUM_LIMBS       (NUM_LIMBS),
    .JOINTS_PER_LIMB (JOINTS_PER_LIMB),
    .NSERVO          (NSERVO),
    .IDX_W           (IDX_W)
  ) u_file (
    .clk     (clk),
    .rst     (rst),
    .idx     (i_cnt),
    .wr      (wr),
    .cur_rd  (cur_rd),
    .home_rd (home_rd)
  );

  sbh_slew_unit u_slew (
    .set_mode  (state == ST_SET),
    .cur       (cur_rd),
    .home      (home_rd),
    .angle     (angle),
    .min_angle (min_angle),
    .max_angle (max_angle),
    .res       (slew)
  );

  always_comb begin
    wr = '0;
    unique case (state)
      ST_SET: begin
        wr.cur_we    = slot_free && addr_ok;
        wr.cur_wdata = slew.value;
      end
      ST_WALK: begin
        // steppers wait for the output slot, the rest snap to home
        wr.cur_we    = !slew.step || slot_free;
        wr.cur_wdata = slew.step ? slew.value : home_rd;
      end
      ST_COPY: begin
        wr.home_we    = 1'b1;
        wr.home_wdata = cur_rd;
      end
      ST_LOAD: begin
        wr.home_we    = addr_ok;
        wr.home_wdata = angle;
      end
      default: wr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_angle <= MIN_RESET;
      max_angle <= MAX_RESET;
      move_en   <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MIN_ANGLE: min_angle <= cfg_data;
        REG_MAX_ANGLE: max_angle <= cfg_data;
        REG_MOVE_EN:   move_en   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      homing_flag <= 1'b0;
      flag_chg    <= 1'b0;
      found       <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            op       <= s_tuser;
            angle    <= in_angle;
            addr_ok  <= in_ok;
            l_cnt    <= (s_tuser == OP_TICK) ? '0 : in_limb;
            j_cnt    <= (s_tuser == OP_TICK) ? '0 : in_joint;
            i_cnt    <= (s_tuser == OP_TICK || s_tuser == OP_CAPTURE) ? '0 :
                        IDX_W'(int'(in_limb) * JOINTS_PER_LIMB + int'(in_joint));
            flag_chg <= (s_tuser == OP_SET_FLAG) && (in_flag != homing_flag);
            found    <= 1'b0;
            case (s_tuser)
              OP_SET: state <= ST_SET;
              OP_TICK: state <= (homing_flag && move_en) ? ST_SCAN : ST_FINISH;
              OP_CAPTURE: state <= ST_COPY;
              OP_LOAD: state <= ST_LOAD;
              OP_SET_FLAG: begin
                homing_flag <= in_flag;
                state       <= ST_FINISH;
              end
              default: state <= ST_FINISH;
            endcase
          end
        end

        ST_SET: begin
          if (slot_free) begin
            o_board  <= addr_ok ? l_cnt[1] : 1'b0;
            o_chan   <= addr_ok ? cnt_chan : '0;
            o_angle  <= addr_ok ? slew.value : '0;
            o_cmd    <= addr_ok;
            o_lim    <= addr_ok && slew.limited;
            o_chg    <= 1'b0;
            o_active <= homing_flag;
            m_tlast  <= 1'b1;
            state    <= ST_IDLE;
          end
        end

        // first pass: find the last servo that will step
        ST_SCAN: begin
          if (slew.step) begin
            last_i <= i_cnt;
            found  <= 1'b1;
          end
          if (at_end) begin
            l_cnt <= '0;
            j_cnt <= '0;
            i_cnt <= '0;
            // the walk still snaps servos when nothing steps
            if (!(found || slew.step)) begin
              homing_flag <= 1'b0;
            end
            state <= ST_WALK;
          end else begin
            if (j_cnt == JOINT_W'(JOINTS_PER_LIMB - 1)) begin
              j_cnt <= '0;
              l_cnt <= l_cnt + 1'b1;
            end else begin
              j_cnt <= j_cnt + 1'b1;
            end
            i_cnt <= i_cnt + 1'b1;
          end
        end

        // second pass: step, command and snap
        ST_WALK: begin
          if (!slew.step || slot_free) begin
            if (slew.step) begin
              o_board  <= l_cnt[1];
              o_chan   <= cnt_chan;
              o_angle  <= slew.value;
              o_cmd    <= 1'b1;
              o_lim    <= slew.limited;
              o_chg    <= 1'b0;
              o_active <= homing_flag;
              m_tlast  <= (i_cnt == last_i);
            end
            if (j_cnt == JOINT_W'(JOINTS_PER_LIMB - 1)) begin
              j_cnt <= '0;
              l_cnt <= l_cnt + 1'b1;
            end else begin
              j_cnt <= j_cnt + 1'b1;
            end
            i_cnt <= i_cnt + 1'b1;
            if (at_end) begin
              state <= found ? ST_IDLE : ST_FINISH;
            end
          end
        end

        ST_COPY: begin
          i_cnt <= i_cnt + 1'b1;
          if (at_end) begin
            state <= ST_FINISH;
          end
        end

        ST_LOAD: state <= ST_FINISH;

        // single status result
        ST_FINISH: begin
          if (slot_free) begin
            o_board  <= 1'b0;
            o_chan   <= '0;
            o_angle  <= '0;
            o_cmd    <= 1'b0;
            o_lim    <= 1'b0;
            o_chg    <= flag_chg && (op == OP_SET_FLAG);
            o_active <= homing_flag;
            m_tlast  <= 1'b1;
            state    <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### verif/servo_bank_homing_stepper_tb.sv
module servo_bank_homing_stepper_tb;
  import sbh_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NLIMB  = NUM_LIMBS_DEFAULT;
  localparam int NJOINT = JOINTS_PER_LIMB_DEFAULT;
  localparam int NSERVO = NLIMB * NJOINT;
  localparam logic [OP_W-1:0] OP_RSVD_LO = OP_W'(OP_SET_FLAG + 1);
  localparam logic [OP_W-1:0] OP_RSVD_HI = {OP_W{1'b1}};
  localparam int NPHASE = 7;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [LIMB_W-1:0]  limb;
    logic [JOINT_W-1:0] joint;
    logic [ANGLE_W-1:0] angle;
    logic               flag;
  } servo_req_t;

  typedef struct packed {
    logic               board;
    logic [CHAN_W-1:0]  channel;
    logic [ANGLE_W-1:0] angle;
    logic               cmd;
    logic               limited;
    logic               changed;
    logic               active;
    logic               last;
  } servo_cmd_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [23:0]          s_tdata = '0;
  logic [OP_W-1:0]      s_tuser = OP_SET;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [23:0]          m_tdata;
  logic                 m_tuser;
  logic                 m_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_MIN_ANGLE;
  logic [ANGLE_W-1:0]   cfg_data = '0;

  servo_bank_homing_stepper dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the servo bank
  logic [ANGLE_W-1:0] cur_ang [NSERVO];
  logic [ANGLE_W-1:0] home_ang [NSERVO];
  logic               homing_on = 1'b0;
  logic [ANGLE_W-1:0] lo_lim = MIN_RESET;
  logic [ANGLE_W-1:0] hi_lim = MAX_RESET;
  logic               move_en = 1'b0;

  servo_req_t servo_req_q [$];
  servo_cmd_t cmd_expect_q [$];

  int errors = 0;
  int reqs_sent = 0;
  int ticks_sent = 0;
  int results_seen = 0;
  int cmds_seen = 0;
  int limited_seen = 0;
  bit no_gaps = 1'b0;

  initial begin
    for (int l = 0; l < NLIMB; l++) begin
      for (int j = 0; j < NJOINT; j++) begin
        cur_ang[l*NJOINT+j]  = START_TAB[l];
        home_ang[l*NJOINT+j] = HOME_TAB[l][j];
      end
    end
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (no_gaps || p < 50) return 0;
    if (p < 88) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // clamp, store and build the command for one servo
  function automatic servo_cmd_t slew_to(int limb, int joint, int target);
    servo_cmd_t c;
    c = '0;
    if (target < int'(lo_lim)) begin
      target = int'(lo_lim);
      c.limited = 1'b1;
    end
    if (target > int'(hi_lim)) begin
      target = int'(hi_lim);
      c.limited = 1'b1;
    end
    cur_ang[limb*NJOINT+joint] = ANGLE_W'(target);
    c.board   = 1'(limb >> 1);
    c.channel = CHAN_W'((limb % 2) * NJOINT + joint);
    c.angle   = ANGLE_W'(target);
    c.cmd     = 1'b1;
    return c;
  endfunction

  function automatic void predict_commands(servo_req_t r);
    servo_cmd_t outs [$];
    servo_cmd_t c;
    bit ok;
    logic changed;
    int idx;
    int diff;
    ok = (int'(r.limb) < NLIMB) && (int'(r.joint) < NJOINT);
    idx = int'(r.limb) * NJOINT + int'(r.joint);
    changed = 1'b0;
    case (r.op)
      OP_SET: if (ok) outs.push_back(slew_to(int'(r.limb), int'(r.joint), int'(r.angle)));
      OP_TICK: begin
        if (homing_on && move_en) begin
          for (int l = 0; l < NLIMB; l++) begin
            for (int j = 0; j < NJOINT; j++) begin
              diff = int'(cur_ang[l*NJOINT+j]) - int'(home_ang[l*NJOINT+j]);
              if (diff > int'(STEP_ANGLE))
                outs.push_back(slew_to(l, j, int'(cur_ang[l*NJOINT+j]) - int'(STEP_ANGLE)));
              else if (diff < -int'(STEP_ANGLE))
                outs.push_back(slew_to(l, j, int'(cur_ang[l*NJOINT+j]) + int'(STEP_ANGLE)));
              else
                cur_ang[l*NJOINT+j] = home_ang[l*NJOINT+j];
            end
          end
          if (outs.size() == 0) homing_on = 1'b0;
        end
      end
      OP_CAPTURE: home_ang = cur_ang;
      OP_LOAD: if (ok) home_ang[idx] = r.angle;
      OP_SET_FLAG: begin
        if (r.flag != homing_on) begin
          homing_on = r.flag;
          changed = 1'b1;
        end
      end
      default: ;
    endcase
    if (outs.size() == 0) begin
      c = '0;
      c.changed = changed;
      outs.push_back(c);
    end
    foreach (outs[k]) begin
      outs[k].active = homing_on;
      outs[k].last   = (k == outs.size() - 1);
      cmd_expect_q.push_back(outs[k]);
    end
  endfunction

  // request driver
  servo_req_t cur_req;
  int tx_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_commands(cur_req);
        reqs_sent++;
        if (cur_req.op == OP_TICK) ticks_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_tvalid <= 1'b0;
        end else if (servo_req_q.size() > 0) begin
          cur_req = servo_req_q.pop_front();
          s_tuser  <= cur_req.op;
          s_tdata  <= {6'b0, cur_req.flag, cur_req.angle, cur_req.joint, cur_req.limb};
          s_tvalid <= 1'b1;
          tx_gap = pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  int rx_gap = 0;
  int rx_hold = 0;
  bit long_hold_done = 1'b0;

  function automatic void check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    servo_cmd_t e;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (cmd_expect_q.size() == 0) begin
          $error("result with no request outstanding: tdata %h", m_tdata);
          errors++;
        end else begin
          e = cmd_expect_q.pop_front();
          if (e.cmd) cmds_seen++;
          if (e.limited) limited_seen++;
          check_field("board", e.board, m_tdata[0]);
          check_field("channel", e.channel, m_tdata[4:1]);
          check_field("servo_angle", e.angle, m_tdata[16:5]);
          check_field("limited", e.limited, m_tdata[17]);
          check_field("flag_changed", e.changed, m_tdata[18]);
          check_field("homing_active", e.active, m_tdata[19]);
          check_field("command_valid", e.cmd, m_tuser);
          check_field("last", e.last, m_tlast);
        end
        rx_gap = pick_gap();
      end
      // one long back-pressure stretch so the block stalls its input
      if (!long_hold_done && results_seen == 40) begin
        long_hold_done = 1'b1;
        rx_hold = 300;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        m_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

  function automatic servo_req_t mk_req(logic [OP_W-1:0] op, int limb, int joint,
                                        int angle, int flag);
    servo_req_t r;
    r.op    = op;
    r.limb  = LIMB_W'(limb);
    r.joint = JOINT_W'(joint);
    r.angle = ANGLE_W'(angle);
    r.flag  = 1'(flag);
    return r;
  endfunction

  function automatic servo_req_t rand_req();
    servo_req_t r;
    int p;
    p = $urandom_range(0, 99);
    r.limb  = LIMB_W'($urandom_range(0, NLIMB - 1));
    r.joint = JOINT_W'(($urandom_range(0, 19) == 0) ? $urandom_range(NJOINT, 7)
                                                    : $urandom_range(0, NJOINT - 1));
    r.angle = ANGLE_W'($urandom_range(0, 4095));
    r.flag  = 1'($urandom_range(0, 1));
    if (p < 30) r.op = OP_SET;
    else if (p < 55) r.op = OP_TICK;
    else if (p < 65) r.op = OP_LOAD;
    else if (p < 70) r.op = OP_CAPTURE;
    else if (p < 92) begin
      r.op = OP_SET_FLAG;
      r.flag = ($urandom_range(0, 3) != 0);
    end else r.op = OP_W'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
    return r;
  endfunction

  task automatic wait_idle();
    do @(posedge clk);
    while (servo_req_q.size() > 0 || s_tvalid || cmd_expect_q.size() > 0);
    // let the block settle back to idle
    repeat (2 * NSERVO + 4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int val);
    cfg_index <= idx;
    cfg_data  <= ANGLE_W'(val);
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    case (idx)
      REG_MIN_ANGLE: lo_lim = ANGLE_W'(val);
      REG_MAX_ANGLE: hi_lim = ANGLE_W'(val);
      REG_MOVE_EN:   move_en = val[0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    static int lo_tab [NPHASE] = '{0, 3000, 4095, 0, -1, 0, 0};
    static int hi_tab [NPHASE] = '{4095, 1000, 4095, 0, -1, 2880, 2880};
    static int en_tab [NPHASE] = '{1, 1, 1, 1, 1, 0, 1};
    int lo_v;
    int hi_v;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values, homing off, movement disabled
    servo_req_q.push_back(mk_req(OP_SET, 0, 0, 0, 0));
    servo_req_q.push_back(mk_req(OP_SET, 3, 4, 4095, 1));
    servo_req_q.push_back(mk_req(OP_SET, 1, 2, 2880, 0));
    servo_req_q.push_back(mk_req(OP_SET, 2, 7, 100, 0));
    servo_req_q.push_back(mk_req(OP_LOAD, 0, 5, 4095, 0));
    for (int op = int'(OP_RSVD_LO); op <= int'(OP_RSVD_HI); op++)
      servo_req_q.push_back(mk_req(OP_W'(op), $urandom_range(0, 3), $urandom_range(0, 7),
                                   $urandom_range(0, 4095), $urandom_range(0, 1)));
    servo_req_q.push_back(mk_req(OP_TICK, 0, 0, 0, 0));
    servo_req_q.push_back(mk_req(OP_SET_FLAG, 0, 0, 0, 1));
    servo_req_q.push_back(mk_req(OP_SET_FLAG, 0, 0, 0, 1));
    servo_req_q.push_back(mk_req(OP_TICK, 0, 0, 0, 0));
    wait_idle();
    write_reg(REG_MOVE_EN, 1);

    servo_req_q.push_back(mk_req(OP_TICK, 0, 0, 0, 0));
    servo_req_q.push_back(mk_req(OP_TICK, 3, 7, 4095, 1));
    servo_req_q.push_back(mk_req(OP_TICK, 0, 0, 0, 0));
    // servo just inside one degree of home is snapped, then the flag drops
    servo_req_q.push_back(mk_req(OP_SET, 2, 0, 1000, 0));
    servo_req_q.push_back(mk_req(OP_CAPTURE, 0, 0, 0, 0));
    servo_req_q.push_back(mk_req(OP_SET, 2, 0, 1010, 0));
    servo_req_q.push_back(mk_req(OP_TICK, 0, 0, 0, 0));
    // home above the clamp is never reached
    servo_req_q.push_back(mk_req(OP_SET_FLAG, 0, 0, 0, 1));
    servo_req_q.push_back(mk_req(OP_LOAD, 0, 1, 4095, 0));
    servo_req_q.push_back(mk_req(OP_TICK, 0, 0, 0, 0));
    servo_req_q.push_back(mk_req(OP_TICK, 0, 0, 0, 0));
    servo_req_q.push_back(mk_req(OP_SET_FLAG, 0, 0, 0, 0));
    servo_req_q.push_back(mk_req(OP_TICK, 0, 0, 0, 0));
    wait_idle();

    for (int ph = 0; ph < NPHASE; ph++) begin
      lo_v = (lo_tab[ph] < 0) ? $urandom_range(0, 4095) : lo_tab[ph];
      hi_v = (hi_tab[ph] < 0) ? $urandom_range(0, 4095) : hi_tab[ph];
      write_reg(REG_MIN_ANGLE, lo_v);
      write_reg(REG_MAX_ANGLE, hi_v);
      // upper data bits are don't-care for the enable
      write_reg(REG_MOVE_EN, ($urandom_range(0, 2047) << 1) | en_tab[ph]);
      no_gaps = (ph == 2);
      servo_req_q.push_back(mk_req(OP_SET_FLAG, 0, 0, $urandom_range(0, 4095), 1));
      repeat (17) servo_req_q.push_back(rand_req());
      wait_idle();
    end

    $display("covered %0d requests (%0d homing ticks), %0d results, %0d commands",
             reqs_sent, ticks_sent, results_seen, cmds_seen);
    $display("%0d commands clamped, %0d limit settings incl. crossed and zero-width",
             limited_seen, NPHASE + 1);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
